[src/ptlac_pkg.sv]
// Shared types, sizes and codes for the path tracker with lookahead and coverage search.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ptlac_pkg;

  // Waypoint queue depth and derived index widths
  localparam int PATH_DEPTH = 256;
  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int CW = $clog2(PATH_DEPTH + 1);

  // Arithmetic widths: squared distance, square root, scale divide
  localparam int D2_W   = 65;
  localparam int RAD_W  = 66;
  localparam int ROOT_W = 33;
  localparam int SQ_CW  = $clog2(ROOT_W);
  localparam int NUM_W  = 55;
  localparam int DEN_W  = 33;
  localparam int DV_CW  = $clog2(NUM_W);

  localparam logic [22:0] SPEED_CAP = 23'd4194304;

  // Configuration register indexes
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_MAX_SPEED   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_LOOKAHEAD   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_GOAL_RADIUS = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_COVERAGE    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_TICKS_TURN  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_TURN_COUNT  = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_PAUSE_TICKS = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_TURN_RATE   = 3'd7;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_TICK   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_TRACK  = 3'd1,
    CMD_ROTATE = 3'd2,
    CMD_PAUSE  = 3'd3,
    CMD_GOAL   = 3'd4,
    CMD_NOPATH = 3'd5
  } motion_t;

  typedef enum logic [1:0] {
    MODE_TRACK  = 2'd0,
    MODE_ROT    = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_DONE   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WAIT,
    ST_EVAL,
    ST_DROP,
    ST_SQ_GO,
    ST_SQ_RUN,
    ST_MUL_X,
    ST_DIV_X,
    ST_DIVW_X,
    ST_MUL_Y,
    ST_DIV_Y,
    ST_DIVW_Y,
    ST_COV,
    ST_COV_DIV,
    ST_COV_WAIT,
    ST_FIN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SCAN,
    PH_LOOK
  } phase_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic [2:0]         command;
    logic signed [23:0] angular_rate;
    logic [8:0]         waypoints_left;
    logic               append_dropped;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic k_inc;
    logic take_best;
    logic drop_best;
    logic pop;
    logic goal_pop;
    logic cov_step;
    logic cov_div;
    logic cov_fix;
    logic sq_start;
    logic mul_go;
    logic div_go;
    logic div_take;
    logic axis_y;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic count_zero;
    logic count_one;
    logic k_last;
    logic d2_lt_best;
    logic d2_le_ld;
    logic d2_le_goal;
    logic cov_active;
    logic cov_need_mod;
    logic sq_done;
    logic div_done;
    logic len_zero;
    logic out_free;
  } dp_stat_t;

endpackage

[src/ptlac_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
// Depends on ptlac_pkg for the radicand and root widths.
`timescale 1ns / 1ps

module ptlac_sqrt import ptlac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [D2_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W+1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [SQ_CW-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [ROOT_W+3:0] wrem;
  logic [ROOT_W+3:0] trial;

  always_comb begin
    wrem  = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial = {2'b00, root_r, 2'b01};
    rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
    if (wrem >= trial) begin
      rem_nxt  = (ROOT_W+2)'(wrem - trial);
      root_nxt = {root_r[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = (ROOT_W+2)'(wrem);
      root_nxt = {root_r[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == SQ_CW'(ROOT_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= {1'b0, radicand};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[src/ptlac_div.sv]
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// velocity scaling and the search segment check. Depends on ptlac_pkg.
`timescale 1ns / 1ps

module ptlac_div import ptlac_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DV_CW-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   part;

  always_comb begin
    part = {rem_r, quo_r[NUM_W-1]};
    if (part >= {1'b0, den_r}) begin
      rem_nxt = DEN_W'(part - {1'b0, den_r});
      quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = DEN_W'(part);
      quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DV_CW'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

[src/ptlac_ctrl.sv]
// Controller for the tracker: sequences the waypoint scan, lookahead drops,
// square root, scaling and search steps. Depends on ptlac_pkg.
`timescale 1ns / 1ps

module ptlac_ctrl import ptlac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  wcnt_r, wcnt_nxt;
  logic        at_goal;

  assign in_ready = (state_r == ST_IDLE);
  assign at_goal  = stat.count_one && stat.d2_le_goal;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_FIRST;
      wcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    wcnt_nxt  = (state_r == ST_WAIT) ? wcnt_r + 2'd1 : 2'd0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.in_op == OP_TICK && !stat.count_zero) begin
            state_nxt = ST_WAIT;
            phase_nxt = PH_FIRST;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      // cover the read, subtract, square and sum stages
      ST_WAIT: if (wcnt_r == 2'd3) state_nxt = ST_EVAL;
      ST_EVAL: begin
        case (phase_r)
          PH_FIRST: begin
            if (at_goal) begin
              state_nxt = stat.cov_active ? ST_COV : ST_FIN;
            end else if (stat.k_last) begin
              state_nxt = ST_DROP;
            end else begin
              state_nxt = ST_WAIT;
              phase_nxt = PH_SCAN;
            end
          end
          PH_SCAN: state_nxt = stat.k_last ? ST_DROP : ST_WAIT;
          PH_LOOK: begin
            if (!stat.count_one && stat.d2_le_ld) state_nxt = ST_WAIT;
            else state_nxt = ST_SQ_GO;
          end
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_DROP: begin
        state_nxt = ST_WAIT;
        phase_nxt = PH_LOOK;
      end
      ST_SQ_GO: state_nxt = ST_SQ_RUN;
      ST_SQ_RUN: begin
        if (stat.sq_done) state_nxt = stat.len_zero ? ST_FIN : ST_MUL_X;
      end
      ST_MUL_X:  state_nxt = ST_DIV_X;
      ST_DIV_X:  state_nxt = ST_DIVW_X;
      ST_DIVW_X: if (stat.div_done) state_nxt = ST_MUL_Y;
      ST_MUL_Y:  state_nxt = ST_DIV_Y;
      ST_DIV_Y:  state_nxt = ST_DIVW_Y;
      ST_DIVW_Y: if (stat.div_done) state_nxt = ST_FIN;
      ST_COV:    state_nxt = stat.cov_need_mod ? ST_COV_DIV : ST_FIN;
      ST_COV_DIV:  state_nxt = ST_COV_WAIT;
      ST_COV_WAIT: if (stat.div_done) state_nxt = ST_FIN;
      ST_FIN:    if (stat.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: cmd.latch = in_valid;
      ST_EVAL: begin
        case (phase_r)
          PH_FIRST: begin
            if (at_goal) begin
              cmd.goal_pop = !stat.cov_active;
            end else begin
              cmd.take_best = 1'b1;
              cmd.k_inc     = !stat.k_last;
            end
          end
          PH_SCAN: begin
            cmd.take_best = stat.d2_lt_best;
            cmd.k_inc     = !stat.k_last;
          end
          PH_LOOK: cmd.pop = !stat.count_one && stat.d2_le_ld;
          default: cmd = '0;
        endcase
      end
      ST_DROP:   cmd.drop_best = 1'b1;
      ST_SQ_GO:  cmd.sq_start = 1'b1;
      ST_MUL_X:  cmd.mul_go = 1'b1;
      ST_DIV_X:  cmd.div_go = 1'b1;
      ST_DIVW_X: cmd.div_take = stat.div_done;
      ST_MUL_Y: begin
        cmd.mul_go = 1'b1;
        cmd.axis_y = 1'b1;
      end
      ST_DIV_Y:  cmd.div_go = 1'b1;
      ST_DIVW_Y: begin
        cmd.div_take = stat.div_done;
        cmd.axis_y   = 1'b1;
      end
      ST_COV:      cmd.cov_step = 1'b1;
      ST_COV_DIV:  cmd.cov_div = 1'b1;
      ST_COV_WAIT: cmd.cov_fix = stat.div_done;
      ST_FIN:      cmd.out_load = stat.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

[src/ptlac_dp.sv]
// Datapath: configuration registers, waypoint memory and queue pointers,
// distance pipeline, search counters and result register.
// Depends on ptlac_pkg, ptlac_sqrt and ptlac_div.
`timescale 1ns / 1ps

module ptlac_dp import ptlac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [23:0]       cfg_wdata,
  input  logic              out_ready,
  output logic              out_valid,
  output out_item_t         out_data
);

  // configuration
  logic [22:0]        max_speed_r, lookahead_r, goal_radius_r;
  logic               coverage_r;
  logic [15:0]        ticks_turn_r, pause_ticks_r;
  logic [7:0]         turn_count_r;
  logic signed [23:0] turn_rate_r;

  // queue and search state
  logic [AW-1:0] head_r, k_r, best_r;
  logic [CW-1:0] count_r;
  mode_t         mode_r;
  logic [23:0]   rot_cnt_r;
  logic [15:0]   pause_cnt_r;

  // waypoint memory
  logic [31:0] mem_x [PATH_DEPTH];
  logic [31:0] mem_y [PATH_DEPTH];
  logic [31:0] rd_x_r, rd_y_r;
  logic        wr_en;
  logic [AW-1:0] rd_addr, wr_addr;

  // distance pipeline
  logic signed [31:0] px_r, py_r;
  logic signed [32:0] dx_r, dy_r, f_dx_r, f_dy_r;
  logic [63:0]        sqx_r, sqy_r;
  logic [D2_W-1:0]    d2_r, bestd_r;
  logic [45:0]        ld2_r, gr2_r;

  // scaling
  logic [NUM_W-1:0]  prod_r;
  logic [22:0]       v_eff;
  logic [ROOT_W-1:0] len;
  logic              sq_done;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num, div_quot;
  logic [DEN_W-1:0]  div_den, div_rem;
  logic [22:0]       q_mag;
  logic              q_neg;
  logic [23:0]       q_val;

  // search step
  logic [15:0] tpt_e, pt_e;
  logic [7:0]  tc_e;
  logic [23:0] rot_lim;
  mode_t       cov_mode;
  logic [23:0] cov_rc;
  logic [15:0] cov_pc;
  motion_t     cov_cmd;
  logic        cov_need_mod;

  // pending result and output register
  motion_t            res_cmd_r;
  logic signed [23:0] res_vx_r, res_vy_r, res_ang_r;
  logic               res_drop_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic full;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] s;
    begin
      s = {1'b0, base} + {1'b0, off};
      if (s >= (AW+1)'(PATH_DEPTH)) s = s - (AW+1)'(PATH_DEPTH);
      return s[AW-1:0];
    end
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] d);
    logic [32:0] n;
    begin
      n = d[32] ? 33'(-d) : 33'(d);
      return n[31:0];
    end
  endfunction

  assign full = (count_r >= CW'(PATH_DEPTH));

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r   <= 23'd65536;
      lookahead_r   <= 23'd32768;
      goal_radius_r <= 23'd13107;
      coverage_r    <= 1'b0;
      ticks_turn_r  <= 16'd20;
      turn_count_r  <= 8'd4;
      pause_ticks_r <= 16'd10;
      turn_rate_r   <= 24'sd32768;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAX_SPEED:   max_speed_r   <= cfg_wdata[22:0];
        CFG_LOOKAHEAD:   lookahead_r   <= cfg_wdata[22:0];
        CFG_GOAL_RADIUS: goal_radius_r <= cfg_wdata[22:0];
        CFG_COVERAGE:    coverage_r    <= cfg_wdata[0];
        CFG_TICKS_TURN:  ticks_turn_r  <= cfg_wdata[15:0];
        CFG_TURN_COUNT:  turn_count_r  <= cfg_wdata[7:0];
        CFG_PAUSE_TICKS: pause_ticks_r <= cfg_wdata[15:0];
        CFG_TURN_RATE:   turn_rate_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ld2_r <= lookahead_r * lookahead_r;
    gr2_r <= goal_radius_r * goal_radius_r;
  end

  // ---------------- waypoint memory ----------------
  assign rd_addr = slot(head_r, k_r);
  assign wr_addr = slot(head_r, count_r[AW-1:0]);
  assign wr_en   = cmd.latch && in_data.operation == OP_APPEND && !full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= in_data.pos_x;
      mem_y[wr_addr] <= in_data.pos_y;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  // ---------------- distance pipeline (free running) ----------------
  always_ff @(posedge clk) begin
    dx_r  <= {rd_x_r[31], rd_x_r} - {px_r[31], px_r};
    dy_r  <= {rd_y_r[31], rd_y_r} - {py_r[31], py_r};
    sqx_r <= mag33(dx_r) * mag33(dx_r);
    sqy_r <= mag33(dy_r) * mag33(dy_r);
    d2_r  <= {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  // ---------------- queue pointers and scan ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.latch) begin
        k_r <= '0;
        case (in_data.operation)
          OP_APPEND: if (!full) count_r <= count_r + 1'b1;
          OP_CLEAR: begin
            count_r <= '0;
            head_r  <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.k_inc) k_r <= k_r + 1'b1;
      // drop everything ahead of the nearest waypoint
      if (cmd.drop_best) begin
        head_r  <= slot(head_r, best_r);
        count_r <= count_r - CW'(best_r);
        k_r     <= '0;
      end
      if (cmd.pop || cmd.goal_pop) begin
        head_r  <= slot(head_r, AW'(1));
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      px_r <= in_data.pos_x;
      py_r <= in_data.pos_y;
    end
    if (cmd.take_best) begin
      best_r  <= k_r;
      bestd_r <= d2_r;
    end
    if (cmd.sq_start) begin
      f_dx_r <= dx_r;
      f_dy_r <= dy_r;
    end
    if (cmd.mul_go) prod_r <= (cmd.axis_y ? mag33(f_dy_r) : mag33(f_dx_r)) * v_eff;
  end

  // ---------------- square root and scaling ----------------
  assign v_eff = (max_speed_r > SPEED_CAP) ? SPEED_CAP : max_speed_r;

  ptlac_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sq_start),
    .radicand (d2_r),
    .done     (sq_done),
    .root     (len)
  );

  assign div_start = cmd.div_go || cmd.cov_div;
  assign div_num   = cmd.cov_div ? NUM_W'(rot_cnt_r) : prod_r;
  assign div_den   = cmd.cov_div ? DEN_W'(tpt_e) : len;

  ptlac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // quotient never exceeds the capped speed
  assign q_mag = div_quot[22:0];
  assign q_neg = cmd.axis_y ? f_dy_r[32] : f_dx_r[32];
  assign q_val = q_neg ? -{1'b0, q_mag} : {1'b0, q_mag};

  // ---------------- search step ----------------
  assign tpt_e   = (ticks_turn_r == '0) ? 16'd1 : ticks_turn_r;
  assign tc_e    = (turn_count_r == '0) ? 8'd1 : turn_count_r;
  assign pt_e    = (pause_ticks_r == '0) ? 16'd1 : pause_ticks_r;
  assign rot_lim = tpt_e * tc_e;

  always_comb begin
    cov_mode     = mode_r;
    cov_rc       = rot_cnt_r;
    cov_pc       = pause_cnt_r;
    cov_cmd      = CMD_PAUSE;
    cov_need_mod = 1'b0;
    if (cov_mode == MODE_TRACK) begin
      cov_mode = MODE_ROT;
      cov_rc   = '0;
      cov_pc   = '0;
    end
    if (cov_mode == MODE_ROT) begin
      cov_cmd = CMD_ROTATE;
      cov_rc  = cov_rc + 24'd1;
      if (cov_rc >= rot_lim) cov_mode = MODE_DONE;
      else cov_need_mod = 1'b1;
    end else begin
      cov_pc = cov_pc + 16'd1;
      if (cov_pc >= pt_e) begin
        cov_mode = MODE_ROT;
        cov_pc   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_TRACK;
      rot_cnt_r   <= '0;
      pause_cnt_r <= '0;
    end else begin
      if (cmd.cov_step) begin
        mode_r      <= cov_mode;
        rot_cnt_r   <= cov_rc;
        pause_cnt_r <= cov_pc;
      end
      if (cmd.goal_pop) mode_r <= MODE_TRACK;
      // a finished segment switches to the pause
      if (cmd.cov_fix && div_rem == '0) mode_r <= MODE_SEARCH;
    end
  end

  // ---------------- pending result ----------------
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      res_cmd_r  <= (in_data.operation == OP_TICK && count_r == '0) ? CMD_NOPATH : CMD_NONE;
      res_vx_r   <= '0;
      res_vy_r   <= '0;
      res_ang_r  <= '0;
      res_drop_r <= (in_data.operation == OP_APPEND) && full;
    end
    if (cmd.goal_pop) res_cmd_r <= CMD_GOAL;
    if (cmd.sq_start) res_cmd_r <= CMD_TRACK;
    if (cmd.cov_step) begin
      res_cmd_r <= cov_cmd;
      if (cov_cmd == CMD_ROTATE) res_ang_r <= turn_rate_r;
    end
    if (cmd.div_take) begin
      if (cmd.axis_y) res_vy_r <= q_val;
      else res_vx_r <= q_val;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.vel_x          <= res_vx_r;
      out_r.vel_y          <= res_vy_r;
      out_r.command        <= res_cmd_r;
      out_r.angular_rate   <= res_ang_r;
      out_r.waypoints_left <= 9'(count_r);
      out_r.append_dropped <= res_drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- status ----------------
  always_comb begin
    stat.in_op        = in_data.operation;
    stat.count_zero   = (count_r == '0);
    stat.count_one    = (count_r == CW'(1));
    stat.k_last       = (CW'(k_r) + CW'(1) == count_r);
    stat.d2_lt_best   = (d2_r < bestd_r);
    stat.d2_le_ld     = (d2_r <= D2_W'(ld2_r));
    stat.d2_le_goal   = (d2_r <= D2_W'(gr2_r));
    stat.cov_active   = coverage_r && mode_r != MODE_DONE;
    stat.cov_need_mod = cov_need_mod;
    stat.sq_done      = sq_done;
    stat.div_done     = div_done;
    stat.len_zero     = (len == '0);
    stat.out_free     = !out_valid_r || out_ready;
  end

endmodule

[src/path_tracker_lookahead_coverage_unit.sv]
// Path tracker top level: waypoint queue, lookahead point selection and goal
// coverage search. Depends on ptlac_pkg, ptlac_ctrl and ptlac_dp.
//
// One item at a time. Append, clear and no-op items, and pose ticks on an
// empty queue, pass from acceptance through the finishing state into the
// output register. A pose tick reads the queue one waypoint at a time
// through the single read port of the waypoint memory and a four-stage
// read/subtract/square/sum pipeline and finishes the distance of each
// waypoint before it reads the next. The scan and the lookahead drops are
// followed by the square root and, for a nonzero length, two divides for
// the velocity. A goal tick with the search enabled uses the divider only
// when a rotation segment boundary is checked. A new item is accepted
// while the previous result waits in the output register.
// The waypoint memory needs no clearing after reset.
`timescale 1ns / 1ps

module path_tracker_lookahead_coverage_unit import ptlac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [23:0]       cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ptlac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptlac_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[verif/path_tracker_lookahead_coverage_unit_test.sv]
// Self-checking testbench for path_tracker_lookahead_coverage_unit: waypoint queue,
// pure-pursuit tracking and goal coverage search, checked against an in-bench predictor.
// Depends on ptlac_pkg and the top level of the block.
`timescale 1ns / 1ps

module path_tracker_lookahead_coverage_unit_test;
  import ptlac_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [23:0]       cfg_wdata = '0;

  path_tracker_lookahead_coverage_unit i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted block state and register copies
  logic signed [31:0] wp_x [PATH_DEPTH];
  logic signed [31:0] wp_y [PATH_DEPTH];
  logic [7:0]  q_head;
  int          q_count;
  mode_t       track_mode;
  logic [23:0] rot_cnt;
  logic [15:0] pause_cnt;
  logic [22:0] max_speed, look_dist, goal_rad;
  logic        cov_goal;
  logic [15:0] ticks_turn, pause_len;
  logic [7:0]  turns;
  logic [23:0] turn_rate;

  out_item_t   expected_results [$];
  int          errors = 0;
  bit          no_idle = 1'b0;

  function automatic logic [65:0] dist_sq(logic signed [31:0] wx, logic signed [31:0] wy,
                                          logic signed [31:0] px, logic signed [31:0] py);
    logic signed [32:0] dx, dy;
    logic [32:0] ax, ay;
    dx = {wx[31], wx} - {px[31], px};
    dy = {wy[31], wy} - {py[31], py};
    ax = dx[32] ? -dx : dx;
    ay = dy[32] ? -dy : dy;
    return 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
  endfunction

  function automatic logic [32:0] floor_sqrt(logic [65:0] s);
    logic [67:0] root, t;
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      t = root | (68'd1 << b);
      if (t * t <= 68'(s)) root = t;
    end
    return root[32:0];
  endfunction

  function automatic logic [23:0] scale_axis(logic signed [32:0] d, logic [63:0] v,
                                             logic [63:0] len);
    logic [63:0] m, q;
    m = d[32] ? 64'(-d) : 64'(d);
    q = (m * v) / len;
    return d[32] ? 24'(-q) : 24'(q);
  endfunction

  function automatic void pop_front();
    if (q_count == 0) return;
    q_head = q_head + 8'd1;
    q_count--;
  endfunction

  function automatic logic [65:0] front_dist(int k, logic signed [31:0] px,
                                             logic signed [31:0] py);
    logic [7:0] s;
    s = q_head + 8'(k);
    return dist_sq(wp_x[s], wp_y[s], px, py);
  endfunction

  function automatic out_item_t next_motion(in_item_t it);
    out_item_t r;
    int best;
    logic [65:0] bd, d, ld2;
    logic signed [32:0] dx, dy;
    logic [32:0] len;
    logic [63:0] v;
    logic [31:0] tpt, tc, pt;
    logic [7:0] s;
    r = '0;
    case (it.operation)
      OP_APPEND: begin
        if (q_count >= PATH_DEPTH) r.append_dropped = 1'b1;
        else begin
          s = q_head + 8'(q_count);
          wp_x[s] = it.pos_x;
          wp_y[s] = it.pos_y;
          q_count++;
        end
      end
      OP_CLEAR: begin
        q_count = 0;
        q_head = '0;
      end
      OP_TICK: begin
        if (q_count == 0) r.command = CMD_NOPATH;
        else if (q_count == 1 &&
                 front_dist(0, it.pos_x, it.pos_y) <= 66'(goal_rad) * 66'(goal_rad)) begin
          if (cov_goal && track_mode != MODE_DONE) begin
            tpt = ticks_turn != 0 ? 32'(ticks_turn) : 32'd1;
            tc  = turns != 0 ? 32'(turns) : 32'd1;
            pt  = pause_len != 0 ? 32'(pause_len) : 32'd1;
            if (track_mode == MODE_TRACK) begin
              track_mode = MODE_ROT;
              rot_cnt = '0;
              pause_cnt = '0;
            end
            if (track_mode == MODE_ROT) begin
              r.command = CMD_ROTATE;
              r.angular_rate = turn_rate;
              rot_cnt = rot_cnt + 24'd1;
              if (32'(rot_cnt) >= tpt * tc) track_mode = MODE_DONE;
              else if (32'(rot_cnt) % tpt == 0) track_mode = MODE_SEARCH;
            end else begin
              r.command = CMD_PAUSE;
              pause_cnt = pause_cnt + 16'd1;
              if (32'(pause_cnt) >= pt) begin
                track_mode = MODE_ROT;
                pause_cnt = '0;
              end
            end
          end else begin
            pop_front();
            track_mode = MODE_TRACK;
            r.command = CMD_GOAL;
          end
        end else begin
          best = 0;
          bd = front_dist(0, it.pos_x, it.pos_y);
          for (int k = 1; k < q_count; k++) begin
            d = front_dist(k, it.pos_x, it.pos_y);
            if (d < bd) begin
              bd = d;
              best = k;
            end
          end
          for (int k = 0; k < best; k++) pop_front();
          ld2 = 66'(look_dist) * 66'(look_dist);
          while (q_count > 1 && front_dist(0, it.pos_x, it.pos_y) <= ld2) pop_front();
          dx = {wp_x[q_head][31], wp_x[q_head]} - {it.pos_x[31], it.pos_x};
          dy = {wp_y[q_head][31], wp_y[q_head]} - {it.pos_y[31], it.pos_y};
          len = floor_sqrt(front_dist(0, it.pos_x, it.pos_y));
          v = max_speed > SPEED_CAP ? 64'(SPEED_CAP) : 64'(max_speed);
          if (len != 0) begin
            r.vel_x = scale_axis(dx, v, 64'(len));
            r.vel_y = scale_axis(dy, v, 64'(len));
          end
          r.command = CMD_TRACK;
        end
      end
      default: ;
    endcase
    r.waypoints_left = 9'(q_count);
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Caller sits at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(op_t op, logic signed [31:0] x, logic signed [31:0] y);
    int g;
    in_item_t it;
    out_item_t exp_item;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    it.operation = op;
    it.pos_x = x;
    it.pos_y = y;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    exp_item = next_motion(it);
    expected_results.insert(expected_results.size(), exp_item);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MAX_SPEED:   max_speed = val[22:0];
      CFG_LOOKAHEAD:   look_dist = val[22:0];
      CFG_GOAL_RADIUS: goal_rad = val[22:0];
      CFG_COVERAGE:    cov_goal = val[0];
      CFG_TICKS_TURN:  ticks_turn = val[15:0];
      CFG_TURN_COUNT:  turns = val[7:0];
      CFG_PAUSE_TICKS: pause_len = val[15:0];
      default:         turn_rate = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_search(logic [15:0] tpt, logic [7:0] tc, logic [15:0] pt);
    write_reg(CFG_TICKS_TURN, 24'(tpt));
    write_reg(CFG_TURN_COUNT, 24'(tc));
    write_reg(CFG_PAUSE_TICKS, 24'(pt));
  endtask

  // Mostly near the origin, sometimes anywhere in the full range
  function automatic logic signed [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 32'($urandom_range(0, 32'h000C0000)) - 32'sh00060000;
    if (r < 92) return $urandom();
    return r[0] ? 32'sh7FFFFFFF : 32'sh80000000;
  endfunction

  task automatic test_directed();
    send_item(OP_TICK, 32'sh0, 32'sh0);
    send_item(OP_NOP, 32'sh7FFFFFFF, 32'sh80000000);
    send_item(OP_APPEND, 32'sh80000000, 32'sh80000000);
    send_item(OP_APPEND, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_item(OP_TICK, 32'sh80000000, 32'sh7FFFFFFF);
    send_item(OP_TICK, 32'sh7FFFFFFF, 32'sh80000000);
    send_item(OP_CLEAR, 32'sh0, 32'sh0);
    // Zero-length direction: all three points sit on the pose
    send_item(OP_APPEND, 32'sh00010000, 32'sh0);
    send_item(OP_APPEND, 32'sh00010000, 32'sh0);
    send_item(OP_APPEND, 32'sh00010000, 32'sh0);
    send_item(OP_TICK, 32'sh00010000, 32'sh0);
    send_item(OP_TICK, 32'sh00011000, 32'sh0);
    send_item(OP_APPEND, -32'sh00030000, 32'sh00020000);
    send_item(OP_APPEND, 32'sh00050000, -32'sh00040000);
    send_item(OP_TICK, 32'sh0, 32'sh0);
    send_item(OP_TICK, 32'sh00050000, -32'sh00040000);
    wait_drained();
    write_reg(CFG_MAX_SPEED, 24'd4194304);
    write_reg(CFG_LOOKAHEAD, 24'd0);
    send_item(OP_APPEND, 32'sh00100000, 32'sh00100000);
    send_item(OP_APPEND, -32'sh00100000, 32'sh00080000);
    send_item(OP_TICK, 32'sh00000100, -32'sh00000100);
    send_item(OP_TICK, 32'sh0, 32'sh0);
    wait_drained();
    write_reg(CFG_MAX_SPEED, 24'h7FFFFF);
    write_reg(CFG_LOOKAHEAD, 24'h7FFFFF);
    send_item(OP_APPEND, -32'sh00100000, 32'sh00100000);
    send_item(OP_TICK, 32'sh0, 32'sh0);
    wait_drained();
    write_reg(CFG_MAX_SPEED, 24'd0);
    send_item(OP_APPEND, 32'sh00030000, 32'sh00030000);
    send_item(OP_TICK, 32'sh0, 32'sh0);
    send_item(OP_CLEAR, 32'sh0, 32'sh0);
  endtask

  task automatic test_queue_full();
    wait_drained();
    write_reg(CFG_MAX_SPEED, 24'd65536);
    write_reg(CFG_LOOKAHEAD, 24'd32768);
    for (int k = 0; k < PATH_DEPTH + 2; k++)
      send_item(OP_APPEND, 32'(k) <<< 14, -(32'(k) <<< 13));
    send_item(OP_TICK, 32'sh00200000, -32'sh00100000);
    send_item(OP_TICK, rand_coord(), rand_coord());
    send_item(OP_CLEAR, 32'sh0, 32'sh0);
  endtask

  task automatic test_coverage();
    wait_drained();
    write_reg(CFG_GOAL_RADIUS, 24'd13107);
    write_reg(CFG_COVERAGE, 24'd1);
    write_reg(CFG_TURN_RATE, 24'h800000);
    set_search(16'd2, 8'd2, 16'd3);
    send_item(OP_APPEND, 32'sh00020000, 32'sh00020000);
    for (int k = 0; k < 14; k++) send_item(OP_TICK, 32'sh00021000, 32'sh00020000);
    // Zero search registers act as one
    wait_drained();
    set_search(16'd0, 8'd0, 16'd0);
    write_reg(CFG_TURN_RATE, 24'h7FFFFF);
    send_item(OP_APPEND, 32'sh0, 32'sh0);
    for (int k = 0; k < 5; k++) send_item(OP_TICK, 32'sh0, 32'sh0);
    // Shrink the search while it runs
    wait_drained();
    set_search(16'd4, 8'd3, 16'd2);
    send_item(OP_APPEND, 32'sh0, 32'sh0);
    for (int k = 0; k < 6; k++) send_item(OP_TICK, 32'sh0, 32'sh0);
    wait_drained();
    set_search(16'd1, 8'd1, 16'd65535);
    for (int k = 0; k < 4; k++) send_item(OP_TICK, 32'sh0, 32'sh0);
    wait_drained();
    set_search(16'd65535, 8'd255, 16'd1);
    write_reg(CFG_TURN_RATE, 24'h000000);
    send_item(OP_APPEND, 32'sh00010000, 32'sh0);
    for (int k = 0; k < 4; k++) send_item(OP_TICK, 32'sh00010000, 32'sh0);
    send_item(OP_CLEAR, 32'sh0, 32'sh0);
  endtask

  task automatic random_config(int phase);
    wait_drained();
    if (phase == 0) begin
      write_reg(CFG_MAX_SPEED, 24'd0);
      write_reg(CFG_LOOKAHEAD, 24'd0);
      write_reg(CFG_GOAL_RADIUS, 24'd0);
    end else if (phase == 1) begin
      write_reg(CFG_MAX_SPEED, 24'd4194304);
      write_reg(CFG_LOOKAHEAD, 24'd4194304);
      write_reg(CFG_GOAL_RADIUS, 24'd4194304);
    end else begin
      write_reg(CFG_MAX_SPEED, 24'($urandom_range(0, 4194304)));
      write_reg(CFG_LOOKAHEAD, 24'($urandom_range(0, 262144)));
      write_reg(CFG_GOAL_RADIUS, 24'($urandom_range(0, 65536)));
    end
    write_reg(CFG_COVERAGE, 24'($urandom_range(0, 1)));
    set_search(16'($urandom_range(1, 4)), 8'($urandom_range(1, 3)),
               16'($urandom_range(1, 3)));
    write_reg(CFG_TURN_RATE, 24'($urandom_range(0, 8388608)) - 24'd4194304);
    no_idle = (phase % 4 == 3);
  endtask

  task automatic test_random();
    logic signed [31:0] bx, by, sx, sy, px, py;
    int n, sent;
    for (int phase = 0; phase < 12; phase++) begin
      random_config(phase);
      if (phase == 6) wait_drained();
      sent = 0;
      while (sent < 140) begin
        if ($urandom_range(0, 9) < 8) begin
          // Well-formed path: clear, a line of waypoints, poses walking along it
          send_item(OP_CLEAR, rand_coord(), rand_coord());
          n = $urandom_range(1, 10);
          bx = rand_coord();
          by = rand_coord();
          sx = 32'($urandom_range(0, 32'h20000)) - 32'sh10000;
          sy = 32'($urandom_range(0, 32'h20000)) - 32'sh10000;
          for (int k = 0; k < n; k++) send_item(OP_APPEND, bx + sx * k, by + sy * k);
          for (int k = 0; k < n + 6; k++) begin
            px = bx + sx * (k < n ? k : n - 1) + 32'($urandom_range(0, 32'h4000)) - 32'sh2000;
            py = by + sy * (k < n ? k : n - 1) + 32'($urandom_range(0, 32'h4000)) - 32'sh2000;
            send_item(OP_TICK, px, py);
          end
          sent += 2 * n + 7;
        end else begin
          send_item(op_t'($urandom_range(0, 3)), $urandom(), $urandom());
          sent++;
        end
      end
    end
  endtask

  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 75) out_ready <= 1'b1;
    else if (r < 97) out_ready <= 1'b0;
    else begin
      out_ready <= 1'b0;
      repeat ($urandom_range(10, 40)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation: %p", out_data);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.vel_x !== e.vel_x) begin
          $error("vel_x expected %0d actual %0d", e.vel_x, out_data.vel_x); errors++;
        end
        if (out_data.vel_y !== e.vel_y) begin
          $error("vel_y expected %0d actual %0d", e.vel_y, out_data.vel_y); errors++;
        end
        if (out_data.command !== e.command) begin
          $error("command expected %0d actual %0d", e.command, out_data.command); errors++;
        end
        if (out_data.angular_rate !== e.angular_rate) begin
          $error("angular_rate expected %0d actual %0d", e.angular_rate,
                 out_data.angular_rate);
          errors++;
        end
        if (out_data.waypoints_left !== e.waypoints_left) begin
          $error("waypoints_left expected %0d actual %0d", e.waypoints_left,
                 out_data.waypoints_left);
          errors++;
        end
        if (out_data.append_dropped !== e.append_dropped) begin
          $error("append_dropped expected %0d actual %0d", e.append_dropped,
                 out_data.append_dropped);
          errors++;
        end
      end
    end
  end

  initial begin
    q_head = '0;
    q_count = 0;
    track_mode = MODE_TRACK;
    rot_cnt = '0;
    pause_cnt = '0;
    max_speed = 23'd65536;
    look_dist = 23'd32768;
    goal_rad = 23'd13107;
    cov_goal = 1'b0;
    ticks_turn = 16'd20;
    turns = 8'd4;
    pause_len = 16'd10;
    turn_rate = 24'd32768;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_queue_full();
    test_coverage();
    test_random();
    wait_drained();
    repeat (200) @(negedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
src/ptlac_pkg.sv
src/ptlac_sqrt.sv
src/ptlac_div.sv
src/ptlac_ctrl.sv
src/ptlac_dp.sv
src/path_tracker_lookahead_coverage_unit.sv
verif/path_tracker_lookahead_coverage_unit_test.sv
